### sv/jetp_pkg.sv
// Shared types and constants for the Julia escape-time pixel engine.
package jetp_pkg;

  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned CW        = 32;   // coordinate word width
  localparam int unsigned PW        = 10;   // pixel index width
  localparam int unsigned NW        = 10;   // iteration count width
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned COLOR_W   = 24;
  localparam int unsigned CFG_IDX_W = 3;

  // escape bound |z|^2 <= 4 at full product precision
  localparam logic [2*CW-1:0] ESC_LIMIT = 64'(4) << (2 * FRAC_BITS);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CfgMaxIter    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CfgPixelStep  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CfgOriginX    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CfgOriginY    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CfgJuliaRe    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CfgJuliaIm    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CfgColorScale = 3'd6;

  // reset values
  localparam logic [NW-1:0]         RstMaxIter    = 10'd50;
  localparam logic [STEP_W-1:0]     RstPixelStep  = 31'd1342177;
  localparam logic signed [CW-1:0]  RstOriginX    = -32'sd536870912;
  localparam logic signed [CW-1:0]  RstOriginY    = -32'sd510027366;
  localparam logic signed [CW-1:0]  RstJuliaRe    = 32'sd76504105;
  localparam logic signed [CW-1:0]  RstJuliaIm    = 32'sd2684355;
  localparam logic [COLOR_W-1:0]    RstColorScale = 24'd265;

  typedef struct packed {
    logic [PW-1:0] pixel_x;
    logic [PW-1:0] pixel_y;
  } pixel_in_t;

  typedef struct packed {
    logic [PW-1:0]      out_x;
    logic [PW-1:0]      out_y;
    logic [NW-1:0]      iter_count;
    logic [COLOR_W-1:0] pixel_color;
  } pixel_out_t;

  typedef struct packed {
    logic [NW-1:0]         max_iter;
    logic [STEP_W-1:0]     pixel_step;
    logic signed [CW-1:0]  origin_x;
    logic signed [CW-1:0]  origin_y;
    logic signed [CW-1:0]  julia_re;
    logic signed [CW-1:0]  julia_im;
    logic [COLOR_W-1:0]    color_scale;
  } cfg_t;

  typedef struct packed {
    logic load;   // latch the pixel
    logic map;    // pixel to complex point
    logic mul;    // form the three squares/products
    logic step;   // z = z*z + k, count up
    logic color;  // form the result color
  } dp_cmd_t;

  typedef struct packed {
    logic done;   // escaped or limit reached
  } dp_status_t;

endpackage

### sv/jetp_cfg.sv
// Configuration register file of the Julia pixel engine.
module jetp_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [jetp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jetp_pkg::CW-1:0]         cfg_wdata_i,
  output jetp_pkg::cfg_t                  cfg_o
);

  jetp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        jetp_pkg::CfgMaxIter:    cfg_d.max_iter    = cfg_wdata_i[jetp_pkg::NW-1:0];
        jetp_pkg::CfgPixelStep:  cfg_d.pixel_step  = cfg_wdata_i[jetp_pkg::STEP_W-1:0];
        jetp_pkg::CfgOriginX:    cfg_d.origin_x    = $signed(cfg_wdata_i);
        jetp_pkg::CfgOriginY:    cfg_d.origin_y    = $signed(cfg_wdata_i);
        jetp_pkg::CfgJuliaRe:    cfg_d.julia_re    = $signed(cfg_wdata_i);
        jetp_pkg::CfgJuliaIm:    cfg_d.julia_im    = $signed(cfg_wdata_i);
        jetp_pkg::CfgColorScale: cfg_d.color_scale = cfg_wdata_i[jetp_pkg::COLOR_W-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_iter    <= jetp_pkg::RstMaxIter;
      cfg_q.pixel_step  <= jetp_pkg::RstPixelStep;
      cfg_q.origin_x    <= jetp_pkg::RstOriginX;
      cfg_q.origin_y    <= jetp_pkg::RstOriginY;
      cfg_q.julia_re    <= jetp_pkg::RstJuliaRe;
      cfg_q.julia_im    <= jetp_pkg::RstJuliaIm;
      cfg_q.color_scale <= jetp_pkg::RstColorScale;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/jetp_dp.sv
// Datapath: pixel mapping, complex squaring iteration and color.
module jetp_dp (
  input  logic                  clk_i,
  input  jetp_pkg::cfg_t        cfg_i,
  input  jetp_pkg::pixel_in_t   pixel_i,
  input  jetp_pkg::dp_cmd_t     cmd_i,
  output jetp_pkg::dp_status_t  status_o,
  output jetp_pkg::pixel_out_t  result_o
);

  localparam int unsigned MAP_W = jetp_pkg::PW + jetp_pkg::STEP_W;
  localparam int unsigned PROD_W = 2 * jetp_pkg::CW;
  localparam int unsigned CPROD_W = jetp_pkg::NW + jetp_pkg::COLOR_W;

  logic [jetp_pkg::PW-1:0]         px_q, py_q;
  logic signed [jetp_pkg::CW-1:0]  re_q, im_q;
  logic signed [PROD_W-1:0]        rr_q, ii_q, ri_q;
  logic [jetp_pkg::NW-1:0]         n_q;
  logic [jetp_pkg::COLOR_W-1:0]    color_q;

  logic [MAP_W-1:0]                map_x, map_y;
  logic [PROD_W-1:0]               mag2;
  logic signed [PROD_W-1:0]        re_sq_diff;
  logic signed [PROD_W-1:0]        re_next_w, im_next_w;
  logic [CPROD_W-1:0]              color_prod;

  assign map_x = MAP_W'(px_q) * MAP_W'(cfg_i.pixel_step);
  assign map_y = MAP_W'(py_q) * MAP_W'(cfg_i.pixel_step);

  // squares are nonnegative and at most 2^62, so the sum cannot wrap
  assign mag2       = $unsigned(rr_q) + $unsigned(ii_q);
  assign re_sq_diff = rr_q - ii_q;
  assign re_next_w  = re_sq_diff >>> jetp_pkg::FRAC_BITS;
  // 2*re*im folded into one less shift
  assign im_next_w  = ri_q >>> (jetp_pkg::FRAC_BITS - 1);

  assign color_prod = CPROD_W'(n_q) * CPROD_W'(cfg_i.color_scale);

  assign status_o.done = (mag2 > jetp_pkg::ESC_LIMIT) || (n_q >= cfg_i.max_iter);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q <= pixel_i.pixel_x;
      py_q <= pixel_i.pixel_y;
    end
    if (cmd_i.map) begin
      re_q <= cfg_i.origin_x + $signed(map_x[jetp_pkg::CW-1:0]);
      im_q <= cfg_i.origin_y + $signed(map_y[jetp_pkg::CW-1:0]);
      n_q  <= '0;
    end
    if (cmd_i.mul) begin
      rr_q <= PROD_W'(re_q) * PROD_W'(re_q);
      ii_q <= PROD_W'(im_q) * PROD_W'(im_q);
      ri_q <= PROD_W'(re_q) * PROD_W'(im_q);
    end
    if (cmd_i.step) begin
      re_q <= re_next_w[jetp_pkg::CW-1:0] + cfg_i.julia_re;
      im_q <= im_next_w[jetp_pkg::CW-1:0] + cfg_i.julia_im;
      n_q  <= jetp_pkg::NW'(n_q + 1'b1);
    end
    if (cmd_i.color) begin
      color_q <= (n_q == cfg_i.max_iter) ? '0 : color_prod[jetp_pkg::COLOR_W-1:0];
    end
  end

  assign result_o.out_x       = px_q;
  assign result_o.out_y       = py_q;
  assign result_o.iter_count  = n_q;
  assign result_o.pixel_color = color_q;

endmodule

### sv/jetp_ctrl.sv
// Controller state machine sequencing map, iterate and color steps.
module jetp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  jetp_pkg::dp_status_t  status_i,
  output jetp_pkg::dp_cmd_t     cmd_o,
  output logic                  busy,
  output logic                  result_valid_o
);

  typedef enum logic [2:0] {
    StIdle,
    StMap,
    StMul,
    StTest,
    StColor
  } state_e;

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  always_comb begin
    state_d = state_q;
    valid_d = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = StMap;
        end
      end
      StMap: begin
        cmd_o.map = 1'b1;
        state_d   = StMul;
      end
      StMul: begin
        cmd_o.mul = 1'b1;
        state_d   = StTest;
      end
      StTest: begin
        if (status_i.done) begin
          state_d = StColor;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = StMul;
        end
      end
      StColor: begin
        cmd_o.color = 1'b1;
        valid_d     = 1'b1;
        state_d     = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = valid_q;

endmodule

### sv/julia_escape_time_pixel.sv
// Julia escape-time pixel engine: top level.
// Each iteration runs the squaring multipliers, then the escape test and update.
// Throughput: one pixel at a time; start is taken again in the cycle the strobe is shown.
// The result strobe lasts one cycle; the receiver cannot stall.
// Reset: configuration registers return to their defaults, the engine goes idle, no strobe.
module julia_escape_time_pixel (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  jetp_pkg::pixel_in_t             pixel_i,
  output logic                            result_valid_o,
  output jetp_pkg::pixel_out_t            result_o,
  input  logic                            cfg_we_i,
  input  logic [jetp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [jetp_pkg::CW-1:0]         cfg_wdata_i
);

  jetp_pkg::cfg_t        cfg;
  jetp_pkg::dp_cmd_t     cmd;
  jetp_pkg::dp_status_t  status;

  jetp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  jetp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  jetp_dp u_dp (
    .clk_i    (clk_i),
    .cfg_i    (cfg),
    .pixel_i  (pixel_i),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (result_o)
  );

  // a transfer in always starts work
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("start transfer did not make the engine busy");

  // a result only follows a busy cycle
  a_valid_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without preceding work");

  // strobe is a single-cycle pulse
  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // the engine is idle while a result is shown
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("engine busy during result strobe");

endmodule
